// ----- rtl/kpv_pkg.sv -----
// Shared types, constants and fixed-point helpers of the position/velocity filter.
package kpv_pkg;

  localparam int unsigned NUM_AXES_DEF  = 3;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DW            = 32;
  localparam int unsigned AXIS_W        = 2;
  localparam int unsigned DT_W          = 17;
  localparam int unsigned PADDR_W       = 5;
  localparam int unsigned WW            = 72;

  // Reset values of the noise registers
  localparam logic signed [DW-1:0] Q_DIAG_RST = 32'sd655;
  localparam logic signed [DW-1:0] R_DIAG_RST = 32'sd65536;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_Q_PP = 3'd0,
    REG_Q_PV = 3'd1,
    REG_Q_VP = 3'd2,
    REG_Q_VV = 3'd3,
    REG_R_PP = 3'd4,
    REG_R_PV = 3'd5,
    REG_R_VP = 3'd6,
    REG_R_VV = 3'd7
  } reg_idx_e;

  // Sequencer steps of the shared multiplier
  typedef enum logic [4:0] {
    MS_ACCDT  = 5'd0,
    MS_VDT    = 5'd1,
    MS_C3DT   = 5'd2,
    MS_C2DT   = 5'd3,
    MS_HALF   = 5'd4,
    MS_MDT    = 5'd5,
    MS_SUM    = 5'd6,
    MS_WAIT   = 5'd7,
    MS_DET_A  = 5'd8,
    MS_DET_B  = 5'd9,
    MS_N0_A   = 5'd10,
    MS_N0_B   = 5'd11,
    MS_N1_A   = 5'd12,
    MS_N1_B   = 5'd13,
    MS_N2_A   = 5'd14,
    MS_N2_B   = 5'd15,
    MS_N3_A   = 5'd16,
    MS_N3_B   = 5'd17,
    MS_FLUSH1 = 5'd18,
    MS_KZ00   = 5'd19,
    MS_KZ01   = 5'd20,
    MS_KZ10   = 5'd21,
    MS_KZ11   = 5'd22,
    MS_C0_A   = 5'd23,
    MS_C0_B   = 5'd24,
    MS_C1_A   = 5'd25,
    MS_C1_B   = 5'd26,
    MS_C2_A   = 5'd27,
    MS_C2_B   = 5'd28,
    MS_C3_A   = 5'd29,
    MS_C3_B   = 5'd30,
    MS_FLUSH2 = 5'd31
  } step_e;

  typedef struct packed {
    logic signed [DW-1:0] q_pp;
    logic signed [DW-1:0] q_pv;
    logic signed [DW-1:0] q_vp;
    logic signed [DW-1:0] q_vv;
    logic signed [DW-1:0] r_pp;
    logic signed [DW-1:0] r_pv;
    logic signed [DW-1:0] r_vp;
    logic signed [DW-1:0] r_vv;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       run;
    step_e      step;
    logic       div_start;
    logic [1:0] div_sel;
    logic       prep;
    logic       store;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } sts_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DW-1:0] sat32(input logic signed [WW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > 72'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -72'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  // Arithmetic right shift by f with round half up
  function automatic logic signed [WW-1:0] rnd_shr(input logic signed [WW-1:0] x,
                                                   input int unsigned f);
    logic signed [WW-1:0] r;
    r = (x + (72'sd1 <<< (f - 1))) >>> f;
    return r;
  endfunction

endpackage

// ----- rtl/kpv_if.sv -----
// Valid/ready channel interfaces for measurement items and estimate items.
interface kpv_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [kpv_pkg::AXIS_W-1:0]            axis;
  logic signed [kpv_pkg::DW-1:0]         meas_pos;
  logic signed [kpv_pkg::DW-1:0]         meas_vel;
  logic signed [kpv_pkg::DW-1:0]         meas_acc;
  logic [kpv_pkg::DT_W-1:0]              step_time;

  modport source (output valid, axis, meas_pos, meas_vel, meas_acc, step_time,
                  input ready);
  modport sink (input valid, axis, meas_pos, meas_vel, meas_acc, step_time,
                output ready);
endinterface

interface kpv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [kpv_pkg::AXIS_W-1:0]            out_axis;
  logic signed [kpv_pkg::DW-1:0]         est_position;
  logic signed [kpv_pkg::DW-1:0]         est_velocity;
  logic                                  singular;

  modport source (output valid, out_axis, est_position, est_velocity, singular,
                  input ready);
  modport sink (input valid, out_axis, est_position, est_velocity, singular,
                output ready);
endinterface

// ----- rtl/kpv_div.sv -----
// Restoring divider: saturated (num << FRAC_BITS) / den, one quotient bit per cycle.
module kpv_div #(
  parameter int unsigned FRAC_BITS = kpv_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [kpv_pkg::DW-1:0] num_i,
  input  logic signed [kpv_pkg::DW-1:0] den_i,
  output logic                          done_o,
  output logic signed [kpv_pkg::DW-1:0] quo_o
);

  localparam int unsigned DW = kpv_pkg::DW;
  localparam int unsigned QW = DW + FRAC_BITS;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] dvd_q, dvd_d;
  logic [DW-1:0] dvs_q;
  logic          neg_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          qbit;
  logic [DW:0]   num_abs;
  logic [DW:0]   den_abs;
  logic signed [QW:0] quo_s;

  assign num_abs = num_i[DW-1] ? -{num_i[DW-1], num_i} : {1'b0, num_i};
  assign den_abs = den_i[DW-1] ? -{den_i[DW-1], den_i} : {1'b0, den_i};

  // One trial subtraction per cycle
  assign trial = {rem_q, dvd_q[QW-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});
  assign rem_d = qbit ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
  assign dvd_d = {dvd_q[QW-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= QW'(num_abs[DW-1:0]) << FRAC_BITS;
      dvs_q <= den_abs[DW-1:0];
      neg_q <= num_i[DW-1] ^ den_i[DW-1];
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  // Sign and saturate the magnitude
  assign quo_s  = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  assign quo_o  = kpv_pkg::sat32(kpv_pkg::WW'(quo_s));
  assign done_o = done_q;

endmodule

// ----- rtl/kpv_dp.sv -----
// Datapath: per-axis state, shared multiplier with write-back decode, gain divider.
module kpv_dp #(
  parameter int unsigned NUM_AXES  = kpv_pkg::NUM_AXES_DEF,
  parameter int unsigned FRAC_BITS = kpv_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  kpv_pkg::cmd_t                     cmd_i,
  output kpv_pkg::sts_t                     sts_o,
  input  kpv_pkg::cfg_t                     cfg_i,
  input  logic [kpv_pkg::AXIS_W-1:0]        axis_i,
  input  logic signed [kpv_pkg::DW-1:0]     meas_pos_i,
  input  logic signed [kpv_pkg::DW-1:0]     meas_vel_i,
  input  logic signed [kpv_pkg::DW-1:0]     meas_acc_i,
  input  logic [kpv_pkg::DT_W-1:0]          step_time_i,
  output logic [kpv_pkg::AXIS_W-1:0]        out_axis_o,
  output logic signed [kpv_pkg::DW-1:0]     est_position_o,
  output logic signed [kpv_pkg::DW-1:0]     est_velocity_o,
  output logic                              singular_o
);

  localparam int unsigned DW = kpv_pkg::DW;
  localparam int unsigned WW = kpv_pkg::WW;
  localparam int unsigned AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam logic signed [WW-1:0] ONE_FX = 72'sd1 <<< FRAC_BITS;
  localparam logic signed [WW-1:0] LIM_FX = 72'sd5 <<< FRAC_BITS;

  // Per-axis state
  logic signed [DW-1:0] pos_st_q [NUM_AXES];
  logic signed [DW-1:0] vel_st_q [NUM_AXES];
  logic signed [DW-1:0] cov_st_q [NUM_AXES][4];

  // Item registers
  logic [AW-1:0]             ax_q;
  logic [kpv_pkg::AXIS_W-1:0] axis_q;
  logic signed [DW-1:0] mp_q, mv_q, ma_q, dt_q;
  logic signed [DW-1:0] pos0_q, vel0_q, c0_q, c1_q, c2_q, c3_q;
  logic signed [DW-1:0] acc_dt_q, tvdt_q, tc2dt_q;
  logic signed [DW-1:0] pos_q, vel_q, m_q;
  logic signed [DW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [DW-1:0] s00_q, s01_q, s10_q, s11_q, det_q;
  logic signed [DW-1:0] n0_q, n1_q, n2_q, n3_q;
  logic signed [DW-1:0] k00_q, k01_q, k10_q, k11_q;
  logic signed [DW-1:0] z0_q, z1_q, a0_q, a1_q, t_q;
  logic signed [DW-1:0] npos_q, nvel_q, nc0_q, nc1_q, nc2_q, nc3_q;
  logic signed [2*DW-1:0] prod_q, acc_q;
  logic                 wb_en_q;
  kpv_pkg::step_e       wb_step_q;

  logic signed [DW-1:0] opa, opb, mq, drnd, m_new, div_num, div_quo;
  logic signed [WW-1:0] half_w, z0_w, z1_w;
  logic                 div_done;
  logic                 ax_oor;

  assign ax_oor = (32'(axis_i) >= NUM_AXES);

  // Multiplier operand selection per step
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd_i.step)
      kpv_pkg::MS_ACCDT:  begin opa = ma_q;     opb = dt_q;  end
      kpv_pkg::MS_VDT:    begin opa = vel0_q;   opb = dt_q;  end
      kpv_pkg::MS_C3DT:   begin opa = c3_q;     opb = dt_q;  end
      kpv_pkg::MS_C2DT:   begin opa = c2_q;     opb = dt_q;  end
      kpv_pkg::MS_HALF:   begin opa = acc_dt_q; opb = dt_q;  end
      kpv_pkg::MS_MDT:    begin opa = m_q;      opb = dt_q;  end
      kpv_pkg::MS_SUM:    ;
      kpv_pkg::MS_WAIT:   ;
      kpv_pkg::MS_DET_A:  begin opa = s00_q;    opb = s11_q; end
      kpv_pkg::MS_DET_B:  begin opa = s01_q;    opb = s10_q; end
      kpv_pkg::MS_N0_A:   begin opa = p00_q;    opb = s11_q; end
      kpv_pkg::MS_N0_B:   begin opa = p01_q;    opb = s10_q; end
      kpv_pkg::MS_N1_A:   begin opa = p01_q;    opb = cfg_i.r_pp; end
      kpv_pkg::MS_N1_B:   begin opa = p00_q;    opb = cfg_i.r_pv; end
      kpv_pkg::MS_N2_A:   begin opa = p10_q;    opb = cfg_i.r_vv; end
      kpv_pkg::MS_N2_B:   begin opa = p11_q;    opb = cfg_i.r_vp; end
      kpv_pkg::MS_N3_A:   begin opa = p11_q;    opb = s00_q; end
      kpv_pkg::MS_N3_B:   begin opa = p10_q;    opb = s01_q; end
      kpv_pkg::MS_FLUSH1: ;
      kpv_pkg::MS_KZ00:   begin opa = k00_q;    opb = z0_q;  end
      kpv_pkg::MS_KZ01:   begin opa = k01_q;    opb = z1_q;  end
      kpv_pkg::MS_KZ10:   begin opa = k10_q;    opb = z0_q;  end
      kpv_pkg::MS_KZ11:   begin opa = k11_q;    opb = z1_q;  end
      kpv_pkg::MS_C0_A:   begin opa = a0_q;     opb = p00_q; end
      kpv_pkg::MS_C0_B:   begin opa = k01_q;    opb = p10_q; end
      kpv_pkg::MS_C1_A:   begin opa = a0_q;     opb = p01_q; end
      kpv_pkg::MS_C1_B:   begin opa = k01_q;    opb = p11_q; end
      kpv_pkg::MS_C2_A:   begin opa = a1_q;     opb = p10_q; end
      kpv_pkg::MS_C2_B:   begin opa = k10_q;    opb = p00_q; end
      kpv_pkg::MS_C3_A:   begin opa = a1_q;     opb = p11_q; end
      kpv_pkg::MS_C3_B:   begin opa = k10_q;    opb = p01_q; end
      kpv_pkg::MS_FLUSH2: ;
    endcase
  end

  // Registered product and write-back tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_en_q <= 1'b0;
    end else begin
      wb_en_q <= cmd_i.run;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= opa * opb;
    wb_step_q <= cmd_i.step;
  end

  // Rounded product, rounded difference of two products
  assign mq     = kpv_pkg::sat32(kpv_pkg::rnd_shr(WW'(prod_q), FRAC_BITS));
  assign drnd   = kpv_pkg::sat32(kpv_pkg::rnd_shr(WW'(acc_q) - WW'(prod_q), FRAC_BITS));
  assign m_new  = kpv_pkg::sat32(WW'(c1_q) + WW'(mq));
  assign half_w = (WW'(mq) + 72'sd1) >>> 1;

  // Innovations clamped to plus or minus five
  assign z0_w = WW'(mp_q) - WW'(pos_q);
  assign z1_w = WW'(mv_q) - WW'(vel_q);

  // Gain divider
  always_comb begin
    unique case (cmd_i.div_sel)
      2'd0: div_num = n0_q;
      2'd1: div_num = n1_q;
      2'd2: div_num = n2_q;
      2'd3: div_num = n3_q;
    endcase
  end

  kpv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (det_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ax_q   <= ax_oor ? '0 : AW'(axis_i);
      axis_q <= ax_oor ? '0 : axis_i;
      mp_q   <= meas_pos_i;
      mv_q   <= meas_vel_i;
      ma_q   <= meas_acc_i;
      dt_q   <= DW'(step_time_i);
    end
    if (cmd_i.load) begin
      pos0_q <= pos_st_q[ax_q];
      vel0_q <= vel_st_q[ax_q];
      c0_q   <= cov_st_q[ax_q][0];
      c1_q   <= cov_st_q[ax_q][1];
      c2_q   <= cov_st_q[ax_q][2];
      c3_q   <= cov_st_q[ax_q][3];
    end
    if (wb_en_q) begin
      unique case (wb_step_q)
        kpv_pkg::MS_ACCDT: begin
          acc_dt_q <= mq;
          vel_q    <= kpv_pkg::sat32(WW'(vel0_q) + WW'(mq));
          p11_q    <= kpv_pkg::sat32(WW'(c3_q) + WW'(cfg_i.q_vv));
        end
        kpv_pkg::MS_VDT: tvdt_q <= mq;
        kpv_pkg::MS_C3DT: begin
          m_q   <= m_new;
          p01_q <= kpv_pkg::sat32(WW'(m_new) + WW'(cfg_i.q_pv));
          p10_q <= kpv_pkg::sat32(WW'(c2_q) + WW'(mq) + WW'(cfg_i.q_vp));
        end
        kpv_pkg::MS_C2DT: tc2dt_q <= mq;
        kpv_pkg::MS_HALF: begin
          pos_q <= kpv_pkg::sat32(WW'(pos0_q) + WW'(tvdt_q) + half_w);
        end
        kpv_pkg::MS_MDT: begin
          p00_q <= kpv_pkg::sat32(WW'(c0_q) + WW'(tc2dt_q) + WW'(mq) + WW'(cfg_i.q_pp));
        end
        kpv_pkg::MS_SUM: begin
          s00_q <= kpv_pkg::sat32(WW'(p00_q) + WW'(cfg_i.r_pp));
          s01_q <= kpv_pkg::sat32(WW'(p01_q) + WW'(cfg_i.r_pv));
          s10_q <= kpv_pkg::sat32(WW'(p10_q) + WW'(cfg_i.r_vp));
          s11_q <= kpv_pkg::sat32(WW'(p11_q) + WW'(cfg_i.r_vv));
        end
        kpv_pkg::MS_DET_A, kpv_pkg::MS_N0_A, kpv_pkg::MS_N1_A,
        kpv_pkg::MS_N2_A, kpv_pkg::MS_N3_A: acc_q <= prod_q;
        kpv_pkg::MS_DET_B: det_q <= drnd;
        kpv_pkg::MS_N0_B:  n0_q  <= drnd;
        kpv_pkg::MS_N1_B:  n1_q  <= drnd;
        kpv_pkg::MS_N2_B:  n2_q  <= drnd;
        kpv_pkg::MS_N3_B:  n3_q  <= drnd;
        kpv_pkg::MS_KZ00, kpv_pkg::MS_KZ10, kpv_pkg::MS_C0_A,
        kpv_pkg::MS_C1_A, kpv_pkg::MS_C2_A, kpv_pkg::MS_C3_A: t_q <= mq;
        kpv_pkg::MS_KZ01: npos_q <= kpv_pkg::sat32(WW'(pos_q) + WW'(t_q) + WW'(mq));
        kpv_pkg::MS_KZ11: nvel_q <= kpv_pkg::sat32(WW'(vel_q) + WW'(t_q) + WW'(mq));
        kpv_pkg::MS_C0_B: nc0_q <= kpv_pkg::sat32(WW'(t_q) - WW'(mq));
        kpv_pkg::MS_C1_B: nc1_q <= kpv_pkg::sat32(WW'(t_q) - WW'(mq));
        kpv_pkg::MS_C2_B: nc2_q <= kpv_pkg::sat32(WW'(t_q) - WW'(mq));
        kpv_pkg::MS_C3_B: nc3_q <= kpv_pkg::sat32(WW'(t_q) - WW'(mq));
        default: ;
      endcase
    end
    if (div_done) begin
      unique case (cmd_i.div_sel)
        2'd0: k00_q <= div_quo;
        2'd1: k01_q <= div_quo;
        2'd2: k10_q <= div_quo;
        2'd3: k11_q <= div_quo;
      endcase
    end
    if (cmd_i.prep) begin
      z0_q <= (z0_w > LIM_FX) ? LIM_FX[DW-1:0] :
              (z0_w < -LIM_FX) ? DW'(-LIM_FX) : z0_w[DW-1:0];
      z1_q <= (z1_w > LIM_FX) ? LIM_FX[DW-1:0] :
              (z1_w < -LIM_FX) ? DW'(-LIM_FX) : z1_w[DW-1:0];
      a0_q <= kpv_pkg::sat32(ONE_FX - WW'(k00_q));
      a1_q <= kpv_pkg::sat32(ONE_FX - WW'(k11_q));
    end
    if (cmd_i.out_load) begin
      out_axis_o     <= axis_q;
      est_position_o <= (det_q == '0) ? pos0_q : npos_q;
      est_velocity_o <= (det_q == '0) ? vel0_q : nvel_q;
      singular_o     <= (det_q == '0);
    end
  end

  // Axis state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_st_q[i] <= '0;
        vel_st_q[i] <= '0;
        for (int j = 0; j < 4; j++) begin
          cov_st_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.store) begin
      pos_st_q[ax_q]    <= npos_q;
      vel_st_q[ax_q]    <= nvel_q;
      cov_st_q[ax_q][0] <= nc0_q;
      cov_st_q[ax_q][1] <= nc1_q;
      cov_st_q[ax_q][2] <= nc2_q;
      cov_st_q[ax_q][3] <= nc3_q;
    end
  end

  assign sts_o.det_zero = (det_q == '0);
  assign sts_o.div_done = div_done;

endmodule

// ----- rtl/kpv_ctrl.sv -----
// Controller: item handshake and the step sequence of one filter update.
module kpv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  kpv_pkg::sts_t sts_i,
  output kpv_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_PRED  = 9'b000000100,
    S_DIVGO = 9'b000001000,
    S_DIVWT = 9'b000010000,
    S_PREP  = 9'b000100000,
    S_UPD   = 9'b001000000,
    S_STORE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  kpv_pkg::step_e step_q, step_d;
  logic [1:0]     sel_q, sel_d;
  logic           out_valid_q, out_valid_d;
  logic           accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o           = '0;
    cmd_o.step      = step_q;
    cmd_o.div_sel   = sel_q;
    cmd_o.capture   = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        step_d     = kpv_pkg::MS_ACCDT;
        state_d    = S_PRED;
      end
      S_PRED: begin
        cmd_o.run = 1'b1;
        step_d    = kpv_pkg::step_e'(step_q + 5'd1);
        if (step_q == kpv_pkg::MS_FLUSH1) begin
          sel_d   = 2'd0;
          state_d = sts_i.det_zero ? S_OUT : S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVWT;
      end
      S_DIVWT: begin
        if (sts_i.div_done) begin
          sel_d   = sel_q + 2'd1;
          state_d = (sel_q == 2'd3) ? S_PREP : S_DIVGO;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = kpv_pkg::MS_KZ00;
        state_d    = S_UPD;
      end
      S_UPD: begin
        cmd_o.run = 1'b1;
        step_d    = kpv_pkg::step_e'(step_q + 5'd1);
        if (step_q == kpv_pkg::MS_FLUSH2) state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= kpv_pkg::MS_ACCDT;
      sel_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && out_valid_q) |-> out_ready_i)
    else $error("pending estimate overwritten");

  a_pred_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRED && step_q == kpv_pkg::MS_FLUSH1)
      |=> (state_q == S_OUT || state_q == S_DIVGO))
    else $error("prediction phase left to wrong state");

  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_LOAD) else $error("accepted item not loaded");
`endif

endmodule

// ----- rtl/kalman_pos_vel_filter_core.sv -----
// Top level: register port, channel interfaces, controller and datapath.
// Per-axis position/velocity Kalman filter in signed fixed point. One item at a
// time: an item that updates is sequenced through the shared 32x32 multiplier
// (32 sequenced steps) and the four gain divisions in a restoring divider that
// makes one quotient bit per cycle (32 + FRAC_BITS bits each). A singular item
// skips the divisions and update. A finished estimate waits in an output
// register, so the next item is taken meanwhile.
// Noise registers sit at byte address 4*index, reads return the stored value.
module kalman_pos_vel_filter_core #(
  parameter int unsigned NUM_AXES  = kpv_pkg::NUM_AXES_DEF,
  parameter int unsigned FRAC_BITS = kpv_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kpv_pkg::PADDR_W-1:0]    paddr,
  input  logic [kpv_pkg::DW-1:0]         pwdata,
  output logic [kpv_pkg::DW-1:0]         prdata,
  output logic                           pready,
  kpv_in_if.sink                         in_i,
  kpv_out_if.source                      out_o
);

  kpv_pkg::cfg_t     cfg_q;
  kpv_pkg::cmd_t     cmd;
  kpv_pkg::sts_t     sts;
  kpv_pkg::reg_idx_e reg_idx;
  logic              cfg_wr;

  assign reg_idx = kpv_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Noise registers; diagonal entries are 31-bit unsigned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.q_pp <= kpv_pkg::Q_DIAG_RST;
      cfg_q.q_pv <= '0;
      cfg_q.q_vp <= '0;
      cfg_q.q_vv <= kpv_pkg::Q_DIAG_RST;
      cfg_q.r_pp <= kpv_pkg::R_DIAG_RST;
      cfg_q.r_pv <= '0;
      cfg_q.r_vp <= '0;
      cfg_q.r_vv <= kpv_pkg::R_DIAG_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        kpv_pkg::REG_Q_PP: cfg_q.q_pp <= {1'b0, pwdata[30:0]};
        kpv_pkg::REG_Q_PV: cfg_q.q_pv <= pwdata;
        kpv_pkg::REG_Q_VP: cfg_q.q_vp <= pwdata;
        kpv_pkg::REG_Q_VV: cfg_q.q_vv <= {1'b0, pwdata[30:0]};
        kpv_pkg::REG_R_PP: cfg_q.r_pp <= {1'b0, pwdata[30:0]};
        kpv_pkg::REG_R_PV: cfg_q.r_pv <= pwdata;
        kpv_pkg::REG_R_VP: cfg_q.r_vp <= pwdata;
        kpv_pkg::REG_R_VV: cfg_q.r_vv <= {1'b0, pwdata[30:0]};
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_idx)
      kpv_pkg::REG_Q_PP: prdata = cfg_q.q_pp;
      kpv_pkg::REG_Q_PV: prdata = cfg_q.q_pv;
      kpv_pkg::REG_Q_VP: prdata = cfg_q.q_vp;
      kpv_pkg::REG_Q_VV: prdata = cfg_q.q_vv;
      kpv_pkg::REG_R_PP: prdata = cfg_q.r_pp;
      kpv_pkg::REG_R_PV: prdata = cfg_q.r_pv;
      kpv_pkg::REG_R_VP: prdata = cfg_q.r_vp;
      kpv_pkg::REG_R_VV: prdata = cfg_q.r_vv;
    endcase
  end

  kpv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kpv_dp #(
    .NUM_AXES  (NUM_AXES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_i          (cfg_q),
    .axis_i         (in_i.axis),
    .meas_pos_i     (in_i.meas_pos),
    .meas_vel_i     (in_i.meas_vel),
    .meas_acc_i     (in_i.meas_acc),
    .step_time_i    (in_i.step_time),
    .out_axis_o     (out_o.out_axis),
    .est_position_o (out_o.est_position),
    .est_velocity_o (out_o.est_velocity),
    .singular_o     (out_o.singular)
  );

endmodule
